/* rtl/mp4s_pkg.sv */
// Shared types and constants for the MP4 signature sniffer.
// Holds the sniffer state record, the byte item and step result types, and brand codes.
// No dependencies; mp4s_step and the top level refer to it by scoped names.
package mp4s_pkg;

    // Header layout
    localparam int unsigned MIN_HEADER_SIZE = 12;
    localparam int unsigned FIRST_BRAND_POS = 16;
    localparam int unsigned BRAND_LEN       = 4;

    // "ftyp" box type, one byte per position 4..7
    localparam logic [7:0] FTYP_F = 8'h66;
    localparam logic [7:0] FTYP_T = 8'h74;
    localparam logic [7:0] FTYP_Y = 8'h79;
    localparam logic [7:0] FTYP_P = 8'h70;

    // Brand codes, first three bytes of a brand
    localparam logic [23:0] BRAND_MP4 = 24'h6D7034;
    localparam logic [23:0] BRAND_QT  = 24'h717420;
    localparam logic [23:0] BRAND_ISO = 24'h69736F;

    typedef struct packed {
        logic [31:0] byte_position;
        logic [31:0] box_length;
        logic        header_ok;
        logic [23:0] brand_hold;
        logic        verdict_given;
    } mp4s_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } mp4s_item_t;

    typedef struct packed {
        logic valid;
        logic is_mp4;
    } mp4s_result_t;

    localparam mp4s_state_t STATE_RESET = '{
        byte_position: 32'd0,
        box_length:    32'd0,
        header_ok:     1'b1,
        brand_hold:    24'd0,
        verdict_given: 1'b0
    };

    // Expected "ftyp" byte for the low two bits of the position
    function automatic logic [7:0] ftyp_byte(input logic [1:0] sel);
        logic [7:0] val;
        unique case (sel)
            2'd0: val = FTYP_F;
            2'd1: val = FTYP_T;
            2'd2: val = FTYP_Y;
            2'd3: val = FTYP_P;
            default: val = FTYP_F;
        endcase
        return val;
    endfunction

endpackage

/* rtl/mp4s_if.sv */
// Valid/ready channel interfaces for the MP4 signature sniffer.
// mp4s_byte_if carries stream bytes in, mp4s_verdict_if carries verdicts out.
// No dependencies.
interface mp4s_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                    output ready);
endinterface

interface mp4s_verdict_if;
    logic valid;
    logic ready;
    logic is_mp4;

    modport source (output valid, output is_mp4, input ready);
    modport sink   (input valid, input is_mp4, output ready);
endinterface

/* rtl/mp4s_step.sv */
// Per-byte decision logic of the MP4 signature sniffer.
// Takes the current state and one byte item, gives the next state and any verdict.
// Depends on mp4s_pkg.
module mp4s_step (
    input  mp4s_pkg::mp4s_state_t  state,
    input  mp4s_pkg::mp4s_item_t   item,
    input  logic                   allow_extra_brands,
    output mp4s_pkg::mp4s_state_t  state_next,
    output mp4s_pkg::mp4s_result_t result
);

    localparam logic [31:0] HEADER_DECIDE_POS = 32'(mp4s_pkg::MIN_HEADER_SIZE - 1);
    localparam logic [31:0] FIRST_CHECK_POS   = 32'(mp4s_pkg::FIRST_BRAND_POS - 1);
    localparam logic [31:0] FIRST_MATCH_POS   =
        32'(mp4s_pkg::FIRST_BRAND_POS + mp4s_pkg::BRAND_LEN - 1);

    mp4s_pkg::mp4s_state_t cur;
    logic [31:0] q;
    logic [32:0] q_plus_one;
    logic        brand_hit;
    logic        decided;
    logic        decided_val;

    // Restart on a first-byte mark
    assign cur = item.first_byte ? mp4s_pkg::STATE_RESET : state;
    assign q   = cur.byte_position;
    assign q_plus_one = {1'b0, q} + 33'd1;

    // Brand compare on the three held bytes
    assign brand_hit = (cur.brand_hold == mp4s_pkg::BRAND_MP4) ||
                       (allow_extra_brands && ((cur.brand_hold == mp4s_pkg::BRAND_QT) ||
                                               (cur.brand_hold == mp4s_pkg::BRAND_ISO)));

    always_comb
    begin
        state_next  = cur;
        decided     = 1'b0;
        decided_val = 1'b0;
        result      = '0;
        if (!cur.verdict_given)
        begin
            // Check header fields and brand positions
            if (q < 32'd4)
            begin
                state_next.box_length = {cur.box_length[23:0], item.data_byte};
                if ((q == 32'd3) && (item.data_byte[1:0] != 2'd0))
                begin
                    state_next.header_ok = 1'b0;
                end
            end
            else if (q < 32'd8)
            begin
                if (item.data_byte != mp4s_pkg::ftyp_byte(q[1:0]))
                begin
                    state_next.header_ok = 1'b0;
                end
            end
            else if (q == HEADER_DECIDE_POS)
            begin
                if (!cur.header_ok)
                begin
                    decided = 1'b1;
                end
                else if (cur.brand_hold == mp4s_pkg::BRAND_MP4)
                begin
                    decided     = 1'b1;
                    decided_val = 1'b1;
                end
            end
            else if ((q >= FIRST_CHECK_POS) && (q[1:0] == 2'd3))
            begin
                if ((q >= FIRST_MATCH_POS) && brand_hit)
                begin
                    decided     = 1'b1;
                    decided_val = 1'b1;
                end
                else if (q_plus_one >= {1'b0, cur.box_length})
                begin
                    decided = 1'b1;
                end
            end

            // Shift the byte into the brand window
            state_next.brand_hold = {cur.brand_hold[15:0], item.data_byte};

            // Close out a stream that ends undecided
            if (!decided && item.last_byte)
            begin
                decided = 1'b1;
            end

            if (decided)
            begin
                state_next.verdict_given = 1'b1;
                result.valid  = 1'b1;
                result.is_mp4 = decided_val;
            end
            else
            begin
                state_next.byte_position = q_plus_one[31:0];
            end
        end
    end

endmodule

/* rtl/mp4_signature_sniffer_unit.sv */
// Top level of the MP4 signature sniffer: input register, state, result register.
// Depends on mp4s_pkg, mp4s_if (mp4s_byte_if, mp4s_verdict_if) and mp4s_step.
//
// Usage:
//   bytes   : valid/ready channel of stream bytes, one per item, with first_byte
//             and last_byte marks. first_byte restarts the sniffer at byte 0.
//   verdict : valid/ready channel carrying is_mp4, one item per stream, issued at
//             byte 11, at a brand boundary, or at the last_byte mark.
//   cfg_wr_en / cfg_wr_data : write allow_extra_brands (reset 1); write only
//             while the block is idle.
// Throughput: one byte per cycle while the verdict channel is not stalled; the accepted
//   byte sits in an input register and the decision logic updates the state and result
//   register once the result slot is free. A verdict is presented from the result register.
// Reset: clears the input and result registers and returns the state to byte 0
//   with the header marked good; bytes after reset without first_byte continue
//   that fresh stream.
// Stall: while a verdict waits, the input register holds and bytes is not ready
//   once it is full; nothing is dropped. Bytes after a verdict are absorbed
//   silently until the next first_byte.
module mp4_signature_sniffer_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    mp4s_byte_if.sink             bytes,
    mp4s_verdict_if.source        verdict,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data
);

    logic                   allow_extra_brands_reg;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    mp4s_pkg::mp4s_item_t   s1_item_reg;
    mp4s_pkg::mp4s_state_t  state_reg;
    mp4s_pkg::mp4s_state_t  state_next;
    mp4s_pkg::mp4s_result_t step_result;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_is_mp4_reg;
    logic                   out_free;
    logic                   s1_go;
    logic                   in_fire;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_extra_brands_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            allow_extra_brands_reg <= cfg_wr_data;
        end
    end

    // Handshake: advance the input register whenever the result slot can take an item
    assign out_free    = !out_valid_reg || verdict.ready;
    assign s1_go       = s1_valid_reg && out_free;
    assign bytes.ready = !s1_valid_reg || out_free;
    assign in_fire     = bytes.valid && bytes.ready;

    assign s1_valid_next = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.data_byte  <= bytes.data_byte;
            s1_item_reg.first_byte <= bytes.first_byte;
            s1_item_reg.last_byte  <= bytes.last_byte;
        end
    end

    // Decision logic
    mp4s_step u_step (
        .state              (state_reg),
        .item               (s1_item_reg),
        .allow_extra_brands (allow_extra_brands_reg),
        .state_next         (state_next),
        .result             (step_result)
    );

    // Sniffer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mp4s_pkg::STATE_RESET;
        end
        else if (s1_go)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: load a new verdict, drop one that was taken
    always_comb
    begin
        priority if (s1_go && step_result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (verdict.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && step_result.valid)
        begin
            out_is_mp4_reg <= step_result.is_mp4;
        end
    end

    assign verdict.valid  = out_valid_reg;
    assign verdict.is_mp4 = out_is_mp4_reg;

`ifndef SYNTHESIS
    // A verdict marks the stream as decided
    a_verdict_sets_given: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && step_result.valid) |=> state_reg.verdict_given)
        else $error("verdict issued without marking the stream decided");

    // No second verdict for a decided stream without a restart
    a_one_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && state_reg.verdict_given && !s1_item_reg.first_byte) |-> !step_result.valid)
        else $error("second verdict for one stream");

    // A new verdict only appears for a stream marked decided
    a_out_from_decided: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> state_reg.verdict_given)
        else $error("result register loaded without a decision");

    // The input register never advances into a blocked result slot
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !verdict.ready && s1_valid_reg) |=> (s1_valid_reg && out_valid_reg))
        else $error("item advanced past a stalled verdict");
`endif

endmodule

/* test/tb_mp4_signature_sniffer_unit.sv */
// Testbench for mp4_signature_sniffer_unit: drives byte streams and checks every verdict.
// A directed table runs first, then random streams built around "ftyp" headers and brands.
// Depends on mp4s_pkg, mp4s_if (mp4s_byte_if, mp4s_verdict_if) and the sniffer RTL.
module tb_mp4_signature_sniffer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    // How the expected verdict of a directed row is obtained
    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_FALSE,
        EXP_TRUE
    } row_exp_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_first;
        logic       is_last;
        row_exp_t   pin;
    } dir_row_t;

    // Directed streams: mp4 major brand with no start mark, an absorbed byte,
    // a one-byte stream, and a bad-size header cut short
    localparam int DIR_ROWS = 19;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b0, EXP_MODEL},
        '{8'h00, 1'b0, 1'b0, EXP_MODEL},
        '{8'h00, 1'b0, 1'b0, EXP_MODEL},
        '{8'h18, 1'b0, 1'b0, EXP_MODEL},
        '{8'h66, 1'b0, 1'b0, EXP_MODEL},
        '{8'h74, 1'b0, 1'b0, EXP_MODEL},
        '{8'h79, 1'b0, 1'b0, EXP_MODEL},
        '{8'h70, 1'b0, 1'b0, EXP_MODEL},
        '{8'h6D, 1'b0, 1'b0, EXP_MODEL},
        '{8'h70, 1'b0, 1'b0, EXP_MODEL},
        '{8'h34, 1'b0, 1'b0, EXP_MODEL},
        '{8'hFF, 1'b0, 1'b0, EXP_TRUE},
        '{8'h00, 1'b0, 1'b1, EXP_MODEL},
        '{8'hFF, 1'b1, 1'b1, EXP_FALSE},
        '{8'hFF, 1'b1, 1'b0, EXP_MODEL},
        '{8'hFF, 1'b0, 1'b0, EXP_MODEL},
        '{8'hFF, 1'b0, 1'b0, EXP_MODEL},
        '{8'hFF, 1'b0, 1'b0, EXP_MODEL},
        '{8'h00, 1'b0, 1'b1, EXP_FALSE}
    };

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    mp4s_byte_if    bytes_ch ();
    mp4s_verdict_if verdict_ch ();

    mp4_signature_sniffer_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes       (bytes_ch),
        .verdict     (verdict_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Sniffer state as the checker tracks it
    logic [31:0] sniff_pos;
    logic [31:0] sniff_box;
    bit          sniff_hdr_ok;
    logic [23:0] sniff_tail;
    bit          sniff_done;
    bit          extra_brands_en;

    bit          pending_verdicts [$];
    logic [7:0]  stream_bytes [$];

    bit gaps_on;
    bit stalls_on;
    int stall_left;
    int err_count;
    int sniffed_items;
    int stream_count;
    int verdicts_checked;
    int true_verdicts;
    int cycle_count;
    bit got_verdict;

    always #5 clk = ~clk;

    // Advance the sniffer by one byte; returns 0 when the byte is absorbed after a verdict
    function automatic bit sniff_step(input logic [7:0] b, input bit is_first,
                                      input bit is_last, output bit emit,
                                      output bit verdict);
        logic [31:0] q;
        logic [7:0]  tag;
        bit          decided;
        emit = 1'b0;
        verdict = 1'b0;
        decided = 1'b0;
        if (is_first)
        begin
            sniff_pos = '0;
            sniff_box = '0;
            sniff_hdr_ok = 1'b1;
            sniff_tail = '0;
            sniff_done = 1'b0;
        end
        if (sniff_done)
            return 1'b0;

        q = sniff_pos;
        if (q < 4)
        begin
            // Collect the big-endian box size
            sniff_box = {sniff_box[23:0], b};
            if (q == 3 && sniff_box[1:0] != 2'b00)
                sniff_hdr_ok = 1'b0;
        end
        else if (q < 8)
        begin
            case (q[1:0])
                2'd0: tag = mp4s_pkg::FTYP_F;
                2'd1: tag = mp4s_pkg::FTYP_T;
                2'd2: tag = mp4s_pkg::FTYP_Y;
                default: tag = mp4s_pkg::FTYP_P;
            endcase
            if (b != tag)
                sniff_hdr_ok = 1'b0;
        end
        else if (q == 11)
        begin
            // Judge header and major brand
            if (!sniff_hdr_ok)
                decided = 1'b1;
            else if (sniff_tail == mp4s_pkg::BRAND_MP4)
            begin
                decided = 1'b1;
                verdict = 1'b1;
            end
        end
        else if (q >= 15 && q[1:0] == 2'd3)
        begin
            // Test a compatible brand, or give up at the end of the box
            if (q >= 19 && (sniff_tail == mp4s_pkg::BRAND_MP4 || (extra_brands_en &&
                (sniff_tail == mp4s_pkg::BRAND_QT || sniff_tail == mp4s_pkg::BRAND_ISO))))
            begin
                decided = 1'b1;
                verdict = 1'b1;
            end
            else if ({1'b0, q} + 33'd1 >= {1'b0, sniff_box})
                decided = 1'b1;
        end

        sniff_tail = {sniff_tail[15:0], b};
        if (!decided && is_last)
            decided = 1'b1;
        if (decided)
        begin
            sniff_done = 1'b1;
            emit = 1'b1;
            return 1'b1;
        end
        sniff_pos = q + 32'd1;
        return 1'b1;
    endfunction

    // Offer one byte, hold it until accepted, and record the verdict it causes
    task automatic push_byte(input logic [7:0] d, input bit is_first, input bit is_last,
                             input row_exp_t pin);
        int gap;
        bit emit;
        bit verdict;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            bytes_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bytes_ch.valid      <= 1'b1;
        bytes_ch.data_byte  <= d;
        bytes_ch.first_byte <= is_first;
        bytes_ch.last_byte  <= is_last;
        do @(posedge clk); while (!bytes_ch.ready);

        void'(sniff_step(d, is_first, is_last, emit, verdict));
        sniffed_items++;
        if (pin != EXP_MODEL)
        begin
            if (!emit)
            begin
                $error("is_mp4: table row expects a verdict of %0b, predictor gives none",
                       pin == EXP_TRUE);
                err_count++;
            end
            verdict = (pin == EXP_TRUE);
        end
        if (emit)
            pending_verdicts.push_back(verdict);
    endtask

    // Hold the input side until every verdict is back and the pipeline is empty
    task automatic drain_results(input int settle);
        bytes_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_extra_brands(input bit en);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        @(posedge clk);
        extra_brands_en = en;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Brand code: mostly known brands, some near misses and random codes
    function automatic logic [23:0] pick_brand();
        case ($urandom_range(0, 6))
            0, 1: return mp4s_pkg::BRAND_MP4;
            2: return mp4s_pkg::BRAND_QT;
            3: return mp4s_pkg::BRAND_ISO;
            4: return mp4s_pkg::BRAND_MP4 ^ (24'd1 << $urandom_range(0, 23));
            5: return ($urandom_range(0, 1) != 0)
                   ? mp4s_pkg::BRAND_QT ^ (24'd1 << $urandom_range(0, 23))
                   : mp4s_pkg::BRAND_ISO ^ (24'd1 << $urandom_range(0, 23));
            default: return 24'($urandom);
        endcase
    endfunction

    // Build one stream: mostly well-formed ftyp boxes, some noise, corrupt or cut short
    task automatic make_stream();
        logic [31:0] box;
        logic [23:0] brand;
        int          n_brands;
        int          cut;
        int          pos;
        stream_bytes.delete();
        if ($urandom_range(0, 9) < 2)
        begin
            repeat ($urandom_range(1, 40)) stream_bytes.push_back(8'($urandom));
            return;
        end

        box = 32'(4 * $urandom_range(2, 12));
        case ($urandom_range(0, 9))
            0: box = $urandom & 32'hFFFF_FFFC;
            1: box = box | 32'($urandom_range(1, 3));
            2: box = 32'd0;
            default: ;
        endcase
        for (int i = 3; i >= 0; i--)
            stream_bytes.push_back(box[8*i +: 8]);
        stream_bytes.push_back(mp4s_pkg::FTYP_F);
        stream_bytes.push_back(mp4s_pkg::FTYP_T);
        stream_bytes.push_back(mp4s_pkg::FTYP_Y);
        stream_bytes.push_back(mp4s_pkg::FTYP_P);

        // Major brand, minor version, then compatible brands
        n_brands = $urandom_range(0, 8);
        for (int k = 0; k < n_brands + 2; k++)
        begin
            brand = (k == 1) ? 24'($urandom) : pick_brand();
            stream_bytes.push_back(brand[23:16]);
            stream_bytes.push_back(brand[15:8]);
            stream_bytes.push_back(brand[7:0]);
            stream_bytes.push_back(($urandom_range(0, 1) != 0) ? 8'h20 : 8'($urandom));
        end

        if ($urandom_range(0, 7) == 0)
        begin
            pos = $urandom_range(0, stream_bytes.size() - 1);
            stream_bytes[pos] = stream_bytes[pos] ^ 8'(1 << $urandom_range(0, 7));
        end
        if ($urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(1, stream_bytes.size());
            while (stream_bytes.size() > cut)
                void'(stream_bytes.pop_back());
        end
    endtask

    // Random streams until the byte count reaches the target
    task automatic run_streams(input int target, input bit allow_idle);
        bit mark_first;
        bit mark_last;
        int n;
        while (sniffed_items < target)
        begin
            gaps_on   = allow_idle && ($urandom_range(0, 3) != 0);
            stalls_on = allow_idle && ($urandom_range(0, 3) != 0);
            make_stream();
            mark_first = ($urandom_range(0, 15) != 0);
            mark_last  = ($urandom_range(0, 7) != 0);
            n = stream_bytes.size();
            for (int i = 0; i < n; i++)
                push_byte(stream_bytes[i], mark_first && i == 0, mark_last && i == n - 1,
                          EXP_MODEL);
            stream_count++;
        end
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
    endtask

    // Check each verdict against the oldest expectation and stall the output at random
    always @(posedge clk)
    begin
        if (!rst_n)
            verdict_ch.ready <= 1'b0;
        else
        begin
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("is_mp4: no verdict expected, got %0b", verdict_ch.is_mp4);
                    err_count++;
                end
                else
                begin
                    got_verdict = pending_verdicts.pop_front();
                    if (verdict_ch.is_mp4 !== got_verdict)
                    begin
                        $error("is_mp4: expected %0b, got %0b", got_verdict,
                               verdict_ch.is_mp4);
                        err_count++;
                    end
                    verdicts_checked++;
                    if (got_verdict)
                        true_verdicts++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                verdict_ch.ready <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                verdict_ch.ready <= 1'b0;
            end
            else
                verdict_ch.ready <= 1'b1;
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        bytes_ch.valid = 1'b0;
        bytes_ch.data_byte = '0;
        bytes_ch.first_byte = 1'b0;
        bytes_ch.last_byte = 1'b0;
        verdict_ch.ready = 1'b0;
        sniff_pos = '0;
        sniff_box = '0;
        sniff_hdr_ok = 1'b1;
        sniff_tail = '0;
        sniff_done = 1'b0;
        extra_brands_en = 1'b1;
        gaps_on = 1'b0;
        stalls_on = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table with the reset value of the brand switch
        for (int r = 0; r < DIR_ROWS; r++)
            push_byte(DIR_TABLE[r].data, DIR_TABLE[r].is_first, DIR_TABLE[r].is_last,
                      DIR_TABLE[r].pin);
        drain_results(6);

        // Random phases across brand settings; the last one runs without idling
        set_extra_brands(1'b0);
        run_streams(sniffed_items + 650, 1'b1);
        drain_results(6);
        set_extra_brands(1'b1);
        run_streams(sniffed_items + 700, 1'b1);
        drain_results(6);
        set_extra_brands(1'($urandom_range(0, 1)));
        run_streams(sniffed_items + 650, 1'b0);

        drain_results(10);
        if (pending_verdicts.size() != 0)
        begin
            $error("is_mp4: %0d expected verdicts never arrived", pending_verdicts.size());
            err_count++;
        end

        $display("Sniffed %0d bytes over %0d random streams plus the directed table.",
                 sniffed_items, stream_count);
        $display("Checked %0d verdicts (%0d true) with extra brands both off and on.",
                 verdicts_checked, true_verdicts);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/mp4s_pkg.sv
rtl/mp4s_if.sv
rtl/mp4s_step.sv
rtl/mp4_signature_sniffer_unit.sv
test/tb_mp4_signature_sniffer_unit.sv
